// ----- design/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

  // number of entries the sorted store holds
  localparam int CAPACITY = 16;
  // occupancy counter width, wide enough to hold CAPACITY itself
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // input beat
  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] item_value;
  } in_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] removed_value;
    status_t            status;
    logic [4:0]         entry_count;
    logic               is_empty;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

// ----- design/spq_ctrl.sv -----
// controller state machine for the sorted priority queue
module spq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output logic           done,
  output spq_pkg::ctrl_t ctrl
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // commands to the datapath
  assign busy      = (state == S_EXEC);
  assign ctrl.load = (state == S_IDLE) && start;
  assign ctrl.exec = (state == S_EXEC);

endmodule

// ----- design/spq_datapath.sv -----
// sorted store of compare and shift cells, occupancy and result register
module spq_datapath (
  input  logic           clk,
  input  logic           rst,
  input  spq_pkg::ctrl_t ctrl,
  input  spq_pkg::in_t   cmd,
  output spq_pkg::out_t  result
);

  spq_pkg::opcode_t                op_q;
  logic signed [31:0]              val_q;
  logic signed [31:0]              entries [spq_pkg::CAPACITY];
  logic signed [31:0]              entry_next [spq_pkg::CAPACITY];
  logic [spq_pkg::CAPACITY-1:0]    less;
  logic [spq_pkg::CNT_W-1:0]       occ;
  logic [spq_pkg::CNT_W-1:0]       occ_next;
  logic                            full;
  logic                            empty;
  logic                            do_insert;
  logic                            do_remove;

  // latch the accepted beat
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op_q  <= cmd.opcode;
      val_q <= cmd.item_value;
    end
  end

  assign full      = (occ == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty     = (occ == '0);
  assign do_insert = (op_q == spq_pkg::OP_INSERT) && !full;
  assign do_remove = (op_q == spq_pkg::OP_REMOVE) && !empty;

  // one compare and shift cell per entry
  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    // new value sorts ahead of this valid entry
    assign less[i] = (spq_pkg::CNT_W'(i) < occ) && (val_q < entries[i]);

    always_comb begin
      entry_next[i] = entries[i];
      if (do_insert) begin
        if ((i > 0) && less[(i > 0) ? i - 1 : 0]) begin
          entry_next[i] = entries[(i > 0) ? i - 1 : 0];
        end else if (less[i] || (spq_pkg::CNT_W'(i) == occ)) begin
          entry_next[i] = val_q;
        end
      end else if (do_remove) begin
        if (i < spq_pkg::CAPACITY - 1) begin
          entry_next[i] = entries[(i < spq_pkg::CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // store update
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
        entries[i] <= entry_next[i];
      end
    end
  end

  // occupancy after this operation
  always_comb begin
    occ_next = occ;
    if (do_insert) begin
      occ_next = occ + spq_pkg::CNT_W'(1);
    end else if (do_remove) begin
      occ_next = occ - spq_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (ctrl.exec) begin
      occ <= occ_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      result.removed_value <= do_remove ? entries[0] : 32'sd0;
      if ((op_q == spq_pkg::OP_INSERT) && full) begin
        result.status <= spq_pkg::ST_FULL;
      end else if ((op_q == spq_pkg::OP_REMOVE) && empty) begin
        result.status <= spq_pkg::ST_EMPTY;
      end else begin
        result.status <= spq_pkg::ST_OK;
      end
      result.entry_count <= 5'(occ_next);
      result.is_empty    <= (occ_next == '0);
    end
  end

endmodule

// ----- design/sorted_priority_queue_core.sv -----
// top level of the sorted priority queue: controller plus datapath
//
//   channel   ports               handshake
//   command   cmd (in_t)          taken when start is high and busy is low
//   result    result (out_t)      valid for the one cycle done is high
//
// each operation first latches the beat; then all compare and shift cells
// update the sorted store at once and the result is registered. done
// rises with that store update; busy is low again in that same cycle,
// so a new command can be taken while the result is shown.
// rst clears the controller and the occupancy count; store contents stay
// unknown until written. the receiver cannot stall the result.
module sorted_priority_queue_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  cmd,
  output logic          done,
  output spq_pkg::out_t result
);

  spq_pkg::ctrl_t ctrl;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  spq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cmd    (cmd),
    .result (result)
  );

endmodule

// ----- design/spq_checker.sv -----
// port-level checks for the sorted priority queue, bound to the top level
module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input logic          done,
  input spq_pkg::out_t result
);

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // a busy cycle is always followed by a result
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done)
    else $error("no result after busy cycle");

  // a result is never shown while busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // empty flag agrees with the count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.is_empty == (result.entry_count == 5'd0)))
    else $error("empty flag disagrees with entry count");

  // refused operations return no value
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != spq_pkg::ST_OK)) |-> (result.removed_value == 32'sd0))
    else $error("refused operation returned a value");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
